// File: rtl/ddo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared constants, types and the arctangent table for the odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

	// angles in 2^-28 rad, carried 34 bits wide while wrapping
	localparam int ANG_W = 34;
	typedef logic signed [ANG_W-1:0] ang_t;
	typedef logic signed [47:0] acc_t;

	localparam ang_t PI_A      = 34'sd843314856;
	localparam ang_t TWO_PI_A  = 34'sd1686629712;
	localparam ang_t HALF_PI_A = 34'sd421657428;
	localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

	localparam int TRIG_ITER_DEF = 24;

	// divider sizes: angle step, linear speed, angular speed
	localparam int ANG_NUM_W = 57;
	localparam int ANG_DEN_W = 20;
	localparam int LIN_NUM_W = 34;
	localparam int ANGV_NUM_W = 30;
	localparam int SPD_DEN_W = 16;

	// register map
	localparam logic [1:0] REG_LEFT  = 2'd0;
	localparam logic [1:0] REG_RIGHT = 2'd1;
	localparam logic [1:0] REG_WBASE = 2'd2;

	localparam logic [23:0] LEFT_RST  = 24'd12569;
	localparam logic [23:0] RIGHT_RST = 24'd12569;
	localparam logic [19:0] WBASE_RST = 20'd4640;

	// atan(2^-i) rounded to 2^-28 rad
	function automatic logic [31:0] atan_entry(input int i);
		logic [31:0] r;
		case (i)
			0: r = 32'd210828714;
			1: r = 32'd124459457;
			2: r = 32'd65760959;
			3: r = 32'd33381290;
			4: r = 32'd16755422;
			5: r = 32'd8385879;
			6: r = 32'd4193963;
			7: r = 32'd2097109;
			8: r = 32'd1048571;
			9: r = 32'd524287;
			default: begin
				if (i <= 28) r = 32'd1 << (28 - i);
				else if (i == 29) r = 32'd1;
				else r = 32'd0;
			end
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/ddo_sdiv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_sdiv
// Bit-serial restoring divider for unsigned magnitudes, one quotient bit
// per cycle; the quotient shifts into the dividend register.
// ----------------------------------------------------------------------------
module ddo_sdiv import ddo_pkg::*; #(
	parameter int NUM_W = ANG_NUM_W,
	parameter int DEN_W = ANG_DEN_W
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  wire [NUM_W-1:0]  dividend,
	input  wire [DEN_W-1:0]  divisor,
	output logic             busy,
	output logic [NUM_W-1:0] quotient
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   trial_sub;
	logic             ge;

	assign trial     = {rem_q, num_q[NUM_W-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign ge        = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (!busy_q) begin
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end
		end else begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q) begin
			if (start) begin
				num_q <= dividend;
				den_q <= divisor;
				rem_q <= '0;
			end
		end else begin
			rem_q <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = num_q;

endmodule
`default_nettype wire

// File: rtl/differential_drive_odometry.sv
`default_nettype none
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Wheel odometry with midpoint-heading pose update, fixed point.
//
// Input items arrive on s_t*: left and right tick deltas and the period in ms.
// Each accepted item gives exactly one result item on m_t*: pose, heading,
// speeds, step values and the running totals. The user must write the three
// calibration registers over the APB port only while no item is in flight;
// the block itself does not enforce this. One item is worked at a time. The
// heading step comes from the bit-serial angle divider; then come the
// heading wrap, repeated until both angles are in range, the fold,
// TRIG_ITERATIONS CORDIC steps, three pose steps and the output step,
// which also waits for the linear and angular speed dividers to finish.
// s_tready is high whenever the core is idle, also while a finished result
// waits in the output register; a stalled receiver only holds the core at
// its last step. Reset clears pose, totals and the output valid, and loads
// the register defaults.
// ----------------------------------------------------------------------------
module differential_drive_odometry import ddo_pkg::*; #(
	parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	// ticks_left[15:0], ticks_right[31:16], elapsed_ms[47:32]
	input  wire  [47:0]  s_tdata,
	output logic         m_tvalid,
	input  wire          m_tready,
	// pos_x[47:0], pos_y[95:48], heading[126:96], linear_speed[166:127],
	// angular_speed[198:167], step_distance[230:199], step_angle[262:231],
	// sum_ticks_left[310:263], sum_ticks_right[358:311],
	// sum_distance[406:359], sum_angle[454:407], zero pad[455]
	output logic [455:0] m_tdata,
	input  wire          psel,
	input  wire          penable,
	input  wire          pwrite,
	input  wire  [3:0]   paddr,
	input  wire  [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	localparam int CNT_W = $clog2(TRIG_ITERATIONS);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MULL = 4'd1;
	localparam logic [3:0] S_MULR = 4'd2;
	localparam logic [3:0] S_SUM  = 4'd3;
	localparam logic [3:0] S_LIN  = 4'd4;
	localparam logic [3:0] S_ANGW = 4'd5;
	localparam logic [3:0] S_ANGV = 4'd6;
	localparam logic [3:0] S_WRAP = 4'd7;
	localparam logic [3:0] S_FOLD = 4'd8;
	localparam logic [3:0] S_ROT  = 4'd9;
	localparam logic [3:0] S_PX   = 4'd10;
	localparam logic [3:0] S_PY   = 4'd11;
	localparam logic [3:0] S_PYA  = 4'd12;
	localparam logic [3:0] S_OUT  = 4'd13;

	// configuration
	logic [23:0] lmpt_q, rmpt_q;
	logic [19:0] wb_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lmpt_q <= LEFT_RST;
			rmpt_q <= RIGHT_RST;
			wb_q   <= WBASE_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_LEFT:  lmpt_q <= pwdata[23:0];
				REG_RIGHT: rmpt_q <= pwdata[23:0];
				REG_WBASE: wb_q   <= pwdata[19:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_LEFT:  prdata = {8'd0, lmpt_q};
			REG_RIGHT: prdata = {8'd0, rmpt_q};
			REG_WBASE: prdata = {12'd0, wb_q};
			default:   prdata = 32'd0;
		endcase
	end

	// working registers
	logic [3:0]          state_q;
	logic signed [15:0]  tl_q, tr_q;
	logic [15:0]         ms_q;
	logic signed [39:0]  dl_q, dr_q;
	logic signed [31:0]  dist_q, ang_q;
	logic                ang_neg_q;
	ang_t                mid_q, thn_q;
	logic signed [31:0]  z_q;
	logic signed [32:0]  x_q, y_q;
	logic                flip_q;
	logic [CNT_W-1:0]    cnt_q;
	logic signed [65:0]  prod_q;
	acc_t                xpos_q, ypos_q, suml_q, sumr_q, sumd_q, suma_q;
	logic signed [30:0]  theta_q;
	logic                m_tvalid_q;
	logic [455:0]        m_tdata_q;

	// shared multiplier
	logic signed [31:0]  mul_a;
	logic signed [33:0]  mul_b;
	logic signed [65:0]  mul_p;
	logic signed [32:0]  cos_v, sin_v;

	assign cos_v = flip_q ? -x_q : x_q;
	assign sin_v = flip_q ? -y_q : y_q;

	always_comb begin
		case (state_q)
			S_MULL: begin
				mul_a = 32'(tl_q);
				mul_b = $signed({10'd0, lmpt_q});
			end
			S_MULR: begin
				mul_a = 32'(tr_q);
				mul_b = $signed({10'd0, rmpt_q});
			end
			S_PX: begin
				mul_a = dist_q;
				mul_b = 34'(cos_v);
			end
			S_PY: begin
				mul_a = dist_q;
				mul_b = 34'(sin_v);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// step distance and wheel difference
	logic signed [40:0] wsum, wdiff, half;
	logic [40:0]        wdiff_mag;
	logic signed [31:0] dist_v;

	assign wsum      = 41'(dl_q) + 41'(dr_q);
	assign wdiff     = 41'(dr_q) - 41'(dl_q);
	assign half      = wsum >>> 1;
	assign wdiff_mag = wdiff[40] ? 41'(-wdiff) : wdiff;

	always_comb begin
		if (half > 41'sd2147483647) dist_v = 32'sh7fffffff;
		else if (half < -41'sd2147483648) dist_v = 32'sh80000000;
		else dist_v = half[31:0];
	end

	// dividers
	logic                 ang_start, lin_start, angv_start;
	logic                 ang_busy, lin_busy, angv_busy;
	logic [ANG_NUM_W-1:0] ang_quo;
	logic [LIN_NUM_W-1:0] lin_quo;
	logic [ANGV_NUM_W-1:0] angv_quo;
	logic [ANG_DEN_W-1:0] wb_div;
	logic [31:0]          dist_mag, ang_mag;
	logic [41:0]          dist_k, ang_k;

	assign ang_start  = state_q == S_SUM;
	assign lin_start  = state_q == S_LIN;
	assign angv_start = state_q == S_ANGV;
	assign wb_div     = (wb_q == '0) ? ANG_DEN_W'(1) : wb_q;
	assign dist_mag   = dist_q[31] ? 32'(-dist_q) : dist_q;
	assign ang_mag    = ang_q[31] ? 32'(-ang_q) : ang_q;
	assign dist_k     = 42'(dist_mag) * 42'd1000;
	assign ang_k      = 42'(ang_mag) * 42'd1000;

	ddo_sdiv #(.NUM_W(ANG_NUM_W), .DEN_W(ANG_DEN_W)) u_ang_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ang_start),
		.dividend ({wdiff_mag, 16'd0}),
		.divisor  (wb_div),
		.busy     (ang_busy),
		.quotient (ang_quo)
	);

	ddo_sdiv #(.NUM_W(LIN_NUM_W), .DEN_W(SPD_DEN_W)) u_lin_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (lin_start),
		.dividend (dist_k[41:8]),
		.divisor  (ms_q),
		.busy     (lin_busy),
		.quotient (lin_quo)
	);

	ddo_sdiv #(.NUM_W(ANGV_NUM_W), .DEN_W(SPD_DEN_W)) u_angv_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (angv_start),
		.dividend (ang_k[41:12]),
		.divisor  (ms_q),
		.busy     (angv_busy),
		.quotient (angv_quo)
	);

	// signed, saturated heading step
	logic signed [31:0] ang_v;
	always_comb begin
		if (ang_neg_q) begin
			if (ang_quo > ANG_NUM_W'(64'd2147483648)) ang_v = 32'sh80000000;
			else ang_v = 32'd0 - ang_quo[31:0];
		end else begin
			if (ang_quo > ANG_NUM_W'(64'd2147483647)) ang_v = 32'sh7fffffff;
			else ang_v = ang_quo[31:0];
		end
	end

	// speeds
	logic signed [39:0] lin_v;
	logic signed [31:0] angv_v;
	always_comb begin
		if (ms_q == '0) begin
			lin_v  = '0;
			angv_v = '0;
		end else begin
			lin_v  = dist_q[31] ? 40'd0 - 40'(lin_quo) : 40'(lin_quo);
			angv_v = ang_q[31] ? 32'd0 - 32'(angv_quo) : 32'(angv_quo);
		end
	end

	// heading wrap, one full turn per pass
	function automatic ang_t wrap_step(input ang_t a);
		ang_t r;
		if (a > PI_A) r = a - TWO_PI_A;
		else if (a <= -PI_A) r = a + TWO_PI_A;
		else r = a;
		return r;
	endfunction

	logic mid_ok, thn_ok;
	assign mid_ok = (mid_q <= PI_A) && (mid_q > -PI_A);
	assign thn_ok = (thn_q <= PI_A) && (thn_q > -PI_A);

	// cordic rotation
	logic [31:0] atan_w [TRIG_ITERATIONS];
	for (genvar g = 0; g < TRIG_ITERATIONS; g++) begin : g_atan
		assign atan_w[g] = atan_entry(g);
	end

	logic signed [32:0] x_sh, y_sh;
	logic signed [31:0] atan_v;
	assign x_sh   = x_q >>> cnt_q;
	assign y_sh   = y_q >>> cnt_q;
	assign atan_v = $signed(atan_w[cnt_q]);

	logic out_free, out_fire;
	assign out_free = !m_tvalid_q || m_tready;
	assign out_fire = (state_q == S_OUT) && !lin_busy && !angv_busy && out_free;
	assign s_tready = state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
			xpos_q     <= '0;
			ypos_q     <= '0;
			theta_q    <= '0;
			suml_q     <= '0;
			sumr_q     <= '0;
			sumd_q     <= '0;
			suma_q     <= '0;
		end else begin
			if (out_fire) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (s_tvalid) state_q <= S_MULL;
				S_MULL: state_q <= S_MULR;
				S_MULR: state_q <= S_SUM;
				S_SUM: begin
					suml_q  <= suml_q + 48'(tl_q);
					sumr_q  <= sumr_q + 48'(tr_q);
					state_q <= S_LIN;
				end
				S_LIN: begin
					sumd_q  <= sumd_q + 48'(dist_q);
					state_q <= S_ANGW;
				end
				S_ANGW: if (!ang_busy) state_q <= S_ANGV;
				S_ANGV: begin
					suma_q  <= suma_q + 48'(ang_q);
					state_q <= S_WRAP;
				end
				S_WRAP: if (mid_ok && thn_ok) state_q <= S_FOLD;
				S_FOLD: state_q <= S_ROT;
				S_ROT: if (cnt_q == CNT_W'(TRIG_ITERATIONS - 1)) state_q <= S_PX;
				S_PX: state_q <= S_PY;
				S_PY: begin
					xpos_q  <= xpos_q + 48'($signed(prod_q[65:30]));
					state_q <= S_PYA;
				end
				S_PYA: begin
					ypos_q  <= ypos_q + 48'($signed(prod_q[65:30]));
					theta_q <= thn_q[30:0];
					state_q <= S_OUT;
				end
				S_OUT: if (out_fire) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				tl_q <= $signed(s_tdata[15:0]);
				tr_q <= $signed(s_tdata[31:16]);
				ms_q <= s_tdata[47:32];
			end
			S_MULL: dl_q <= mul_p[39:0];
			S_MULR: dr_q <= mul_p[39:0];
			S_SUM: begin
				dist_q    <= dist_v;
				ang_neg_q <= wdiff[40];
			end
			S_ANGW: ang_q <= ang_v;
			S_ANGV: begin
				mid_q <= ANG_W'(theta_q) + ANG_W'(ang_q >>> 1);
				thn_q <= ANG_W'(theta_q) + ANG_W'(ang_q);
			end
			S_WRAP: begin
				mid_q <= wrap_step(mid_q);
				thn_q <= wrap_step(thn_q);
			end
			S_FOLD: begin
				x_q   <= CORDIC_GAIN;
				y_q   <= '0;
				cnt_q <= '0;
				if (mid_q > HALF_PI_A) begin
					z_q    <= 32'(mid_q - PI_A);
					flip_q <= 1'b1;
				end else if (mid_q < -HALF_PI_A) begin
					z_q    <= 32'(mid_q + PI_A);
					flip_q <= 1'b1;
				end else begin
					z_q    <= 32'(mid_q);
					flip_q <= 1'b0;
				end
			end
			S_ROT: begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (!z_q[31]) begin
					x_q <= x_q - y_sh;
					y_q <= y_q + x_sh;
					z_q <= z_q - atan_v;
				end else begin
					x_q <= x_q + y_sh;
					y_q <= y_q - x_sh;
					z_q <= z_q + atan_v;
				end
			end
			S_PX: prod_q <= mul_p;
			S_PY: prod_q <= mul_p;
			S_OUT: begin
				if (out_fire) begin
					m_tdata_q <= {1'b0, suma_q, sumd_q, sumr_q, suml_q, ang_q, dist_q,
						angv_v, lin_v, theta_q, ypos_q, xpos_q};
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// checks
	ap_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("item accepted while another is in work");

	ap_valid_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == S_OUT)
		else $error("result raised outside the output step");

	ap_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[126:96]) <= 31'sd843314856 &&
			$signed(m_tdata[126:96]) > -31'sd843314856))
		else $error("heading out of range");

	ap_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!ang_busy && !lin_busy && !angv_busy))
		else $error("divider busy while idle");

endmodule
`default_nettype wire

// File: sim/tb_differential_drive_odometry.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_differential_drive_odometry
// Self-checking bench for the odometry block. Tick and time items are fed
// over the slave stream; each accepted item is run through a local fixed
// point pose model and the resulting record is compared field by field
// with the master stream. Calibration is changed over APB between phases,
// and the source and sink idle at different rates in each phase.
// ----------------------------------------------------------------------------
module tb_differential_drive_odometry import ddo_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_ITER = TRIG_ITER_DEF;
	localparam int STALL_LIMIT = 20000;
	localparam longint PI_Q = 843314856;
	localparam longint HALF_PI_Q = PI_Q / 2;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [47:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [455:0] m_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	differential_drive_odometry i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// model state and calibration
	longint lmm = 12569, rmm = 12569, wbase = 4640;
	longint xp, yp, th, sum_tl, sum_tr, sum_d, sum_a;
	longint atan_q [N_ITER];

	logic [455:0] pose_q [$];
	logic [47:0] tick_q [$];
	int src_idle = 0, snk_stall = 0;
	bit src_hold = 0;
	int n_in = 0, n_out = 0, n_bad = 0, n_cfg = 0, quiet = 0;

	int fld_lo [11] = '{0, 48, 96, 127, 167, 199, 231, 263, 311, 359, 407};
	int fld_w [11] = '{48, 48, 31, 40, 32, 32, 32, 48, 48, 48, 48};
	string fld_name [11] = '{"pos_x", "pos_y", "heading", "linear_speed",
		"angular_speed", "step_distance", "step_angle", "sum_ticks_left",
		"sum_ticks_right", "sum_distance", "sum_angle"};

	function automatic longint sat32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint wrap48(input longint v);
		logic [47:0] t;
		t = v[47:0];
		return longint'($signed(t));
	endfunction

	function automatic longint wrap_rad(input longint a);
		while (a > PI_Q) a -= 2 * PI_Q;
		while (a <= -PI_Q) a += 2 * PI_Q;
		return a;
	endfunction

	task automatic fill_atan();
		longint acc, term;
		int k;
		atan_q[0] = 210828714;
		for (int i = 1; i < N_ITER; i++) begin
			acc = 0;
			for (k = 0; i * (2 * k + 1) <= 60; k++) begin
				term = longint'((64'd1 << 60) >> (i * (2 * k + 1))) / (2 * k + 1);
				acc += (k % 2) ? -term : term;
			end
			atan_q[i] = longint'((acc + (64'sd1 << 31)) >>> 32);
		end
	endtask

	task automatic rotate(input longint a, output longint c, output longint s);
		longint x, y, z, nx;
		bit flip;
		x = 652032874;
		y = 0;
		z = a;
		flip = 0;
		if (z > HALF_PI_Q) begin
			z -= PI_Q;
			flip = 1;
		end else if (z < -HALF_PI_Q) begin
			z += PI_Q;
			flip = 1;
		end
		for (int i = 0; i < N_ITER; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i); y = y + (x >>> i); z -= atan_q[i];
			end else begin
				nx = x + (y >>> i); y = y - (x >>> i); z += atan_q[i];
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	// advance the pose by one tick item and queue the expected record
	task automatic advance_pose(input logic [47:0] d);
		longint tl, tr, ms, dl, dr, wb, dstep, ang, mid, c, s, lin, angv;
		logic [455:0] e;
		tl = longint'($signed(d[15:0]));
		tr = longint'($signed(d[31:16]));
		ms = longint'(d[47:32]);
		dl = tl * lmm;
		dr = tr * rmm;
		wb = (wbase == 0) ? 1 : wbase;
		dstep = sat32((dl + dr) >>> 1);
		ang = sat32(((dr - dl) * 65536) / wb);
		mid = wrap_rad(th + (ang >>> 1));
		rotate(mid, c, s);
		xp = wrap48(xp + ((dstep * c) >>> 30));
		yp = wrap48(yp + ((dstep * s) >>> 30));
		th = wrap_rad(th + ang);
		lin = 0;
		angv = 0;
		if (ms > 0) begin
			lin = (dstep * 1000) / (256 * ms);
			angv = sat32((ang * 1000) / (4096 * ms));
		end
		sum_tl = wrap48(sum_tl + tl);
		sum_tr = wrap48(sum_tr + tr);
		sum_d = wrap48(sum_d + dstep);
		sum_a = wrap48(sum_a + ang);
		e = '0;
		e[47:0] = xp[47:0];
		e[95:48] = yp[47:0];
		e[126:96] = th[30:0];
		e[166:127] = lin[39:0];
		e[198:167] = angv[31:0];
		e[230:199] = dstep[31:0];
		e[262:231] = ang[31:0];
		e[310:263] = sum_tl[47:0];
		e[358:311] = sum_tr[47:0];
		e[406:359] = sum_d[47:0];
		e[454:407] = sum_a[47:0];
		pose_q.push_back(e);
	endtask

	// source side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				advance_pose(s_tdata);
				n_in++;
			end
			if (!s_tvalid || s_tready) begin
				if (!src_hold && tick_q.size() > 0 && $urandom_range(99) >= src_idle) begin
					s_tdata <= tick_q.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// sink side and checking
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_out++;
				if (pose_q.size() == 0) begin
					n_bad++;
					if (n_bad <= 10) $display("unexpected result item %h", m_tdata);
				end else begin
					logic [455:0] e;
					e = pose_q.pop_front();
					for (int f = 0; f < 11; f++) begin
						if (((e ^ m_tdata) >> fld_lo[f]) & ((457'd1 << fld_w[f]) - 1)) begin
							n_bad++;
							if (n_bad <= 10)
								$display("item %0d %s: expected %h got %h", n_out, fld_name[f],
									(e >> fld_lo[f]) & ((457'd1 << fld_w[f]) - 1),
									(m_tdata >> fld_lo[f]) & ((457'd1 << fld_w[f]) - 1));
						end
					end
				end
			end
			m_tready <= ($urandom_range(99) >= snk_stall);
		end
	end

	// watchdog on handshake inactivity
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !arst_n)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("watchdog expired, %0d results outstanding", pose_q.size());
			$display("status: fail");
			$finish;
		end
	end

	task automatic reg_write(input int idx, input logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 4'(idx * 4);
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_LEFT: lmm = longint'(v[23:0]);
			REG_RIGHT: rmm = longint'(v[23:0]);
			REG_WBASE: wbase = longint'(v[19:0]);
			default: ;
		endcase
		n_cfg++;
	endtask

	task automatic drain();
		wait (tick_q.size() == 0 && !s_tvalid && pose_q.size() == 0);
		repeat (120) @(posedge clk);
	endtask

	task automatic put(input int tl, input int tr, input int ms);
		tick_q.push_back({16'(ms), 16'(tr), 16'(tl)});
	endtask

	function automatic logic [15:0] rand_ticks();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($urandom_range(100) - 50);
			2: return 16'($urandom_range(4000) - 2000);
			default: return $urandom_range(1) ? 16'h7fff : 16'h8000;
		endcase
	endfunction

	function automatic logic [15:0] rand_ms();
		case ($urandom_range(9))
			0: return 16'd0;
			1: return 16'($urandom);
			default: return 16'($urandom_range(100, 1));
		endcase
	endfunction

	int src_mode [4] = '{0, 81, 0, 35};
	int snk_mode [4] = '{0, 0, 81, 35};

	initial begin
		xp = 0; yp = 0; th = 0; sum_tl = 0; sum_tr = 0; sum_d = 0; sum_a = 0;
		fill_atan();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset calibration
		put(0, 0, 0);
		put(32767, 32767, 65535);
		put(-32768, -32768, 1);
		put(32767, -32768, 1);
		put(-32768, 32767, 0);
		put(100, -100, 10);
		put(-1, 1, 65535);
		put(5000, 3000, 20);
		put(1, 0, 1);
		drain();

		// zero wheelbase, full per-tick travel, and an unmapped register
		reg_write(REG_LEFT, 32'hffff_ffff);
		reg_write(REG_RIGHT, 32'hffff_ffff);
		reg_write(REG_WBASE, 32'h0);
		reg_write(3, 32'h1234_5678);
		put(32767, -32768, 5);
		put(-32768, 32767, 5);
		put(32767, 32767, 1);
		put(-32768, -32768, 65535);
		put(1, -1, 0);
		put(0, 1, 3);
		put(-7, 0, 7);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					reg_write(REG_LEFT, 12569);
					reg_write(REG_RIGHT, 12600);
					reg_write(REG_WBASE, 4640);
				end
				1: begin
					reg_write(REG_LEFT, 24'hffffff);
					reg_write(REG_RIGHT, 0);
					reg_write(REG_WBASE, 16);
				end
				2: begin
					reg_write(REG_LEFT, $urandom_range(24'hffffff));
					reg_write(REG_RIGHT, $urandom_range(24'hffffff));
					reg_write(REG_WBASE, $urandom_range(20'hfffff, 16));
				end
				default: begin
					reg_write(REG_LEFT, $urandom_range(40000, 1000));
					reg_write(REG_RIGHT, $urandom_range(40000, 1000));
					reg_write(REG_WBASE, 20'hfffff);
				end
			endcase
			src_idle = src_mode[ph];
			snk_stall = snk_mode[ph];
			for (int n = 0; n < 160; n++) begin
				tick_q.push_back({rand_ms(), rand_ticks(), rand_ticks()});
				// hold the source until the core has emptied once per phase
				if (n == 80) begin
					wait (tick_q.size() == 0 && !s_tvalid);
					src_hold = 1;
					wait (pose_q.size() == 0);
					src_hold = 0;
				end
				if (tick_q.size() > 8) wait (tick_q.size() < 4);
			end
			drain();
		end

		$display("%0d tick items in, %0d pose records out, %0d calibration writes", n_in,
			n_out, n_cfg);
		$display("covered saturation, zero wheelbase, zero period and four idle patterns");
		if (n_bad == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", n_bad);
			$display("status: fail");
		end
		$finish;
	end

endmodule
`default_nettype wire
